@@ rtl/sioe_pkg.sv @@
// Shared types, constants and the byte count function for the signed
// integer octet encoder. No dependencies.
`timescale 1ns / 1ps

package sioe_pkg;

    localparam int ValueW   = 64;
    localparam int ByteW    = 8;
    localparam int CntW     = 4;
    localparam int MaxBytes = ValueW / ByteW;

    typedef logic signed [ValueW-1:0] t_value;
    typedef logic [ByteW-1:0]         t_byte;
    typedef logic [CntW-1:0]          t_cnt;

    // Request handed from the input register to the serializer
    typedef struct packed {
        logic valid;
        t_cnt count;
    } t_load;

    // Fewest bytes whose sign extension gives back x (1 to 8).
    // Each width is checked on its own; the smallest match wins.
    function automatic t_cnt value_byte_count(input t_value x);
        t_cnt   n;
        t_value upper;
        n = t_cnt'(MaxBytes);
        for (int k = MaxBytes - 1; k >= 1; k--) begin
            upper = x >>> (ByteW * k - 1);
            if (upper == '0 || upper == '1) begin
                n = t_cnt'(k);
            end
        end
        return n;
    endfunction

endpackage

@@ rtl/sioe_value_if.sv @@
// Input channel of the encoder: valid/ready handshake with a signed value.
// Depends on sioe_pkg.
`timescale 1ns / 1ps

interface sioe_value_if;
    logic             valid;
    logic             ready;
    sioe_pkg::t_value value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

@@ rtl/sioe_byte_if.sv @@
// Output channel of the encoder: valid/ready handshake with one byte and
// an end-of-encoding flag. Depends on sioe_pkg.
`timescale 1ns / 1ps

interface sioe_byte_if;
    logic            valid;
    logic            ready;
    sioe_pkg::t_byte out_byte;
    logic            last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

@@ rtl/sioe_serializer.sv @@
// Output stage: holds one value with its byte count and sends the length
// byte and then the value bytes, most significant first.
// Depends on sioe_pkg and sioe_byte_if.
`timescale 1ns / 1ps

module sioe_serializer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sioe_pkg::t_load  i_load,
    input  sioe_pkg::t_value i_value,
    output logic             o_take,
    sioe_byte_if.source      o_out
);

    logic             r_valid, n_valid;
    sioe_pkg::t_value r_val;
    sioe_pkg::t_cnt   r_cnt;
    sioe_pkg::t_cnt   r_idx, n_idx;

    logic             w_last;
    logic             w_fire;
    logic [2:0]       w_sel;

    // Index 0 is the length byte, index r_cnt the final value byte
    assign w_last = (r_idx == r_cnt);
    assign w_fire = r_valid && o_out.ready;
    assign o_take = !r_valid || (o_out.ready && w_last);

    // Value byte position counted from the least significant end
    assign w_sel = 3'(r_cnt - r_idx);

    assign o_out.valid    = r_valid;
    assign o_out.last     = w_last;
    assign o_out.out_byte = (r_idx == '0) ? sioe_pkg::t_byte'(r_cnt)
                                          : r_val[{w_sel, 3'b000} +: sioe_pkg::ByteW];

    // Next state: load a new request when free, else step through bytes
    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (o_take) begin
            n_valid = i_load.valid;
            n_idx   = '0;
        end else if (w_fire) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_val <= i_value;
            r_cnt <= i_load.count;
        end
    end

endmodule

@@ rtl/signed_integer_octet_encoder.sv @@
// Top level of the signed integer octet encoder.
// Depends on sioe_pkg, sioe_value_if, sioe_byte_if and sioe_serializer.
`timescale 1ns / 1ps

// Encodes each signed 64-bit value as an unconstrained integer, octet
// aligned: a length byte n (1 to 8) followed by n big-endian two's
// complement bytes, the fewest that keep the sign; last marks the final
// byte. A value takes n + 1 bytes on the byte-wide output channel, and
// that channel sets the throughput. A value is taken into an input
// register, its byte count is found there, and it moves to the serializer
// as soon as the previous encoding sends its last byte, so the first byte
// of a value appears from the serializer register after the input register,
// and encodings follow each other with no gap. The input is ready whenever
// the input register is empty or is being emptied that cycle.

module signed_integer_octet_encoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sioe_value_if.sink   i_in,
    sioe_byte_if.source  o_out
);

    logic             r_a_valid, n_a_valid;
    sioe_pkg::t_value r_a_val;

    logic             w_take;
    logic             w_accept;
    sioe_pkg::t_load  w_load;

    assign i_in.ready = !r_a_valid || w_take;
    assign w_accept   = i_in.valid && i_in.ready;

    // Byte count of the held value
    assign w_load.valid = r_a_valid;
    assign w_load.count = sioe_pkg::value_byte_count(r_a_val);

    // Input register occupancy
    always_comb begin
        n_a_valid = r_a_valid;
        if (w_accept) begin
            n_a_valid = 1'b1;
        end else if (w_take) begin
            n_a_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_val <= i_in.value;
        end
    end

    sioe_serializer u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_value (r_a_val),
        .o_take  (w_take),
        .o_out   (o_out)
    );

endmodule

@@ rtl/sioe_checker.sv @@
// Port-level checks on the encoder output stream and their binding to the
// top level. Depends on sioe_pkg.
`timescale 1ns / 1ps

module sioe_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            i_ready,
    input sioe_pkg::t_byte i_byte,
    input logic            i_last
);

    logic           r_first;
    sioe_pkg::t_cnt r_len;
    sioe_pkg::t_cnt r_pos;
    logic           w_fire;

    assign w_fire = i_valid && i_ready;

    // Track the position within the current encoding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
            r_len   <= '0;
            r_pos   <= '0;
        end else if (w_fire) begin
            if (i_last) begin
                r_first <= 1'b1;
            end else if (r_first) begin
                r_first <= 1'b0;
                r_len   <= i_byte[sioe_pkg::CntW-1:0];
                r_pos   <= sioe_pkg::t_cnt'(1);
            end else begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    // Length byte is between 1 and 8
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && r_first) |-> (i_byte >= 8'd1 && i_byte <= 8'd8))
        else $error("length byte out of range");

    // Length byte is never the final byte
    a_len_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && r_first) |-> !i_last)
        else $error("length byte flagged last");

    // last falls exactly on the n-th value byte
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !r_first) |-> (i_last == (r_pos == r_len)))
        else $error("last does not match length");

    // Stalled output holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_byte) && $stable(i_last)))
        else $error("output changed while stalled");

endmodule

bind signed_integer_octet_encoder sioe_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_byte  (o_out.out_byte),
    .i_last  (o_out.last)
);

@@ dv/signed_integer_octet_encoder_tb.sv @@
// Self-checking testbench for the signed integer octet encoder: drives values,
// predicts each length-prefixed byte stream and checks every output byte.
// Depends on sioe_pkg, sioe_value_if, sioe_byte_if and the encoder RTL.
`timescale 1ns / 1ps

module signed_integer_octet_encoder_tb;

    localparam int ClkHalf       = 2;
    localparam int ResetCycles   = 9;
    localparam int RandPerPhase  = 83;
    localparam int StallLimit    = 5000;
    localparam int DrainCycles   = 20;

    // One expected output byte
    typedef struct packed {
        sioe_pkg::t_byte data;
        logic            last;
    } t_octet;

    // Expected byte stream store and checker
    class octet_scoreboard;
        t_octet expected_octets[$];
        int     errors;

        function new();
            errors = 0;
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        // Append one expected byte at the tail of the stream
        function void queue_octet(t_octet o);
            expected_octets.insert(expected_octets.size(), o);
        endfunction

        // Smallest n such that the low 8n bits sign-extend back to v
        function automatic int octets_needed(sioe_pkg::t_value v);
            int               n;
            logic             found;
            sioe_pkg::t_value ext;
            n     = sioe_pkg::MaxBytes;
            found = 1'b0;
            for (int k = 1; k < sioe_pkg::MaxBytes; k++) begin
                ext = (v <<< (sioe_pkg::ValueW - sioe_pkg::ByteW * k))
                      >>> (sioe_pkg::ValueW - sioe_pkg::ByteW * k);
                if (!found && ext == v) begin
                    n     = k;
                    found = 1'b1;
                end
            end
            return n;
        endfunction

        // Length byte, then value bytes most significant first
        function void note_value(sioe_pkg::t_value v);
            int     n;
            t_octet o;
            n = octets_needed(v);
            o.data = sioe_pkg::t_byte'(n);
            o.last = 1'b0;
            queue_octet(o);
            for (int k = n - 1; k >= 0; k--) begin
                o.data = v[sioe_pkg::ByteW*k +: sioe_pkg::ByteW];
                o.last = (k == 0);
                queue_octet(o);
            end
        endfunction

        task check_octet(sioe_pkg::t_byte data, logic last);
            t_octet o;
            if (expected_octets.size() == 0) begin
                report($sformatf("unexpected byte %02h last=%0b", data, last));
            end else begin
                o = expected_octets.pop_front();
                if (data !== o.data)
                    report($sformatf("byte %02h, expected %02h", data, o.data));
                if (last !== o.last)
                    report($sformatf("last %0b, expected %0b (byte %02h)",
                                     last, o.last, o.data));
            end
        endtask

        function int pending();
            return expected_octets.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   stall_cycles;

    octet_scoreboard enc_sb;

    sioe_value_if in_if ();
    sioe_byte_if  out_if ();

    signed_integer_octet_encoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #ClkHalf i_clk = ~i_clk;

    // Receiver backpressure
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Monitors and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                enc_sb.note_value(in_if.value);
            if (out_if.valid && out_if.ready)
                enc_sb.check_octet(out_if.out_byte, out_if.last);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= StallLimit) begin
                $display("ERROR: no request or byte moved for %0d cycles", StallLimit);
                $display("*** FAILED ***");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Offer one value, with random idle cycles ahead of it
    task automatic send_value(sioe_pkg::t_value v);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= v;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every expected byte has come out
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (enc_sb.pending() != 0) @(negedge i_clk);
    endtask

    // Random value: full range, shifted down for every byte count, or near
    // a byte-count boundary
    function automatic sioe_pkg::t_value pick_value();
        sioe_pkg::t_value raw;
        sioe_pkg::t_value edge_val;
        int               n;
        raw = sioe_pkg::t_value'({$urandom, $urandom});
        n   = $urandom_range(1, sioe_pkg::MaxBytes - 1);
        edge_val = sioe_pkg::t_value'(64'sd1 <<< (sioe_pkg::ByteW * n - 1));
        case ($urandom_range(0, 5))
            0:       return raw;
            1:       return -edge_val - sioe_pkg::t_value'($urandom_range(0, 1));
            2:       return edge_val - sioe_pkg::t_value'($urandom_range(0, 1));
            default: return raw >>> $urandom_range(0, sioe_pkg::ValueW - 1);
        endcase
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) send_value(pick_value());
    endtask

    initial begin
        sioe_pkg::t_value directed[$];

        enc_sb       = new();
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        stall_cycles = 0;
        tx_idle_pct  = 10;
        rx_idle_pct  = 72;
        in_if.valid  = 1'b0;
        in_if.value  = '0;
        out_if.ready = 1'b0;

        repeat (ResetCycles) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Zero, sign edges after 1, 2, 4 and 7 bytes, and both extremes
        directed = '{
            64'sd0, 64'sd1, -64'sd1, 64'sd127, 64'sd128, -64'sd128, -64'sd129,
            64'sd255, 64'sd256, 64'sd32767, 64'sd32768, -64'sd32768, -64'sd32769,
            64'sh0000_0000_7FFF_FFFF, 64'sh0000_0000_8000_0000,
            64'shFFFF_FFFF_8000_0000, 64'sh0080_0000_0000_0000,
            64'shFF7F_FFFF_FFFF_FFFF, 64'sh7FFF_FFFF_FFFF_FFFF,
            64'sh8000_0000_0000_0000, 64'shAAAA_AAAA_AAAA_AAAA,
            64'sh5555_5555_5555_5555
        };
        foreach (directed[i]) send_value(directed[i]);
        wait_drained();

        // Slow sink, mostly busy source
        run_random(RandPerPhase);
        wait_drained();

        // Slow source, mostly ready sink
        tx_idle_pct = 72;
        rx_idle_pct = 10;
        run_random(RandPerPhase);
        wait_drained();

        // Full rate both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(RandPerPhase);
        in_if.valid <= 1'b0;

        while (enc_sb.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (enc_sb.errors == 0 && enc_sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
